// File: design/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Field widths, opcodes, status codes and the types that pass between the
// top level and the partition and allocation cells.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int OP_W        = 2;
  localparam int AMT_W       = 16;
  localparam int TAG_W       = 16;
  localparam int ST_W        = 3;
  localparam int PIDX_W      = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_FIT     = 3'd1;
  localparam logic [ST_W-1:0] ST_ALLOC_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [ST_W-1:0] ST_PART_FULL  = 3'd4;

  localparam logic [1:0] PCMD_NONE = 2'd0;
  localparam logic [1:0] PCMD_LOAD = 2'd1;
  localparam logic [1:0] PCMD_TAKE = 2'd2;
  localparam logic [1:0] PCMD_GIVE = 2'd3;

  typedef struct packed {
    logic vld;
    logic found;
  } tok_t;

  typedef struct packed {
    logic [1:0]       code;
    logic [AMT_W-1:0] value;
  } pcmd_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [TAG_W-1:0] tag;
    logic [AMT_W-1:0] size;
  } acmd_t;

endpackage : ffba_pkg
`default_nettype wire

// File: design/ffba_pcell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partition cell
// Holds the free space of one partition, tests a passing search token for a
// first fit and applies load, take and give commands addressed to it.
// ----------------------------------------------------------------------------
module ffba_pcell
  import ffba_pkg::*;
#(
  parameter int PW = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [PW-1:0]    cell_idx,
  input  wire tok_t             tok_i,
  input  wire logic [PW-1:0]    idx_i,
  input  wire logic [AMT_W-1:0] amount_i,
  input  wire pcmd_t            cmd_i,
  input  wire logic [PW-1:0]    cmd_idx_i,
  output tok_t                  tok_o,
  output logic [PW-1:0]         idx_o
);

  logic             valid_r;
  logic [AMT_W-1:0] free_r;
  tok_t             tok_r;
  logic [PW-1:0]    idx_r;
  logic             hit;
  logic             mine;
  logic [AMT_W:0]   sum;

  assign hit  = tok_i.vld && !tok_i.found && valid_r && (free_r >= amount_i);
  assign mine = (cmd_idx_i == cell_idx);
  assign sum  = {1'b0, free_r} + {1'b0, cmd_i.value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_i.vld;
      if (mine && cmd_i.code == PCMD_LOAD) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r.found <= tok_i.found | hit;
    idx_r       <= hit ? cell_idx : idx_i;
    if (mine) begin
      case (cmd_i.code)
        PCMD_LOAD: free_r <= cmd_i.value;
        PCMD_TAKE: free_r <= free_r - cmd_i.value;
        PCMD_GIVE: free_r <= sum[AMT_W] ? '1 : sum[AMT_W-1:0];
        default:   free_r <= free_r;
      endcase
    end
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule : ffba_pcell
`default_nettype wire

// File: design/ffba_acell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocation cell
// Holds one allocation record, tests a passing search token for a free entry
// or a tag match, and takes set and clear commands addressed to it.
// ----------------------------------------------------------------------------
module ffba_acell
  import ffba_pkg::*;
#(
  parameter int AW = 6,
  parameter int PW = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [AW-1:0]    cell_idx,
  input  wire tok_t             tok_i,
  input  wire logic [AW-1:0]    slot_i,
  input  wire logic [PW-1:0]    part_i,
  input  wire logic [AMT_W-1:0] size_i,
  input  wire logic             seek_free_i,
  input  wire logic [TAG_W-1:0] tag_key_i,
  input  wire acmd_t            cmd_i,
  input  wire logic [AW-1:0]    cmd_slot_i,
  input  wire logic [PW-1:0]    wr_part_i,
  output tok_t                  tok_o,
  output logic [AW-1:0]         slot_o,
  output logic [PW-1:0]         part_o,
  output logic [AMT_W-1:0]      size_o
);

  logic             valid_r;
  logic [TAG_W-1:0] tag_r;
  logic [PW-1:0]    part_r;
  logic [AMT_W-1:0] size_r;
  tok_t             tok_r;
  logic [AW-1:0]    slot_r;
  logic [PW-1:0]    tpart_r;
  logic [AMT_W-1:0] tsize_r;
  logic             match;
  logic             hit;
  logic             mine;

  assign match = seek_free_i ? !valid_r : (valid_r && tag_r == tag_key_i);
  assign hit   = tok_i.vld && !tok_i.found && match;
  assign mine  = (cmd_slot_i == cell_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_i.vld;
      if (mine && cmd_i.set) begin
        valid_r <= 1'b1;
      end else if (mine && cmd_i.clr) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r.found <= tok_i.found | hit;
    slot_r      <= hit ? cell_idx : slot_i;
    tpart_r     <= hit ? part_r : part_i;
    tsize_r     <= hit ? size_r : size_i;
    if (mine && cmd_i.set) begin
      tag_r  <= cmd_i.tag;
      part_r <= wr_part_i;
      size_r <= cmd_i.size;
    end
  end

  assign tok_o  = tok_r;
  assign slot_o = slot_r;
  assign part_o = tpart_r;
  assign size_o = tsize_r;

endmodule : ffba_acell
`default_nettype wire

// File: design/first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit block allocator
// Fixed-partition allocator built from a chain of partition cells and a chain
// of allocation cells that a search token walks one cell per clock.
// ----------------------------------------------------------------------------
// Each input transaction carries an opcode: add a partition, allocate a
// request from the lowest-numbered partition that has room, or free an
// allocation by tag. Every input transaction produces exactly one output
// transaction with a status, the assigned tag and the partition index. Add
// transactions and unused opcodes skip the search. Allocate and free wait
// until the search token has left both chains; the token moves through one
// cell of each chain per cycle, so the longer chain sets how long they take.
// One item is handled at a time; a finished result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_PARTITIONS  = 16,
  parameter int MAX_ALLOCATIONS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // opcode [1:0], amount [17:2], release_tag [33:18], zero [39:34]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // status [2:0], given_tag [18:3], partition_index [22:19], zero [23]
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int PW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CW = $clog2(MAX_PARTITIONS + 1);
  localparam int AW = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
  localparam logic [CW-1:0] PCOUNT_MAX = CW'(MAX_PARTITIONS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [AMT_W-1:0]  amount_r;
  logic [TAG_W-1:0]  rtag_r;
  logic              start_r;
  logic              p_done_r, a_done_r;
  logic              fit_r;
  logic [PW-1:0]     fit_idx_r;
  logic              afound_r;
  logic [AW-1:0]     slot_r;
  logic [PW-1:0]     slot_part_r;
  logic [AMT_W-1:0]  slot_size_r;
  logic [CW-1:0]     count_r;
  logic [TAG_W-1:0]  next_tag_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   res_status_r;
  logic [TAG_W-1:0]  res_tag_r;
  logic [PIDX_W-1:0] res_part_r;

  logic              in_fire;
  logic              fin_fire;
  logic [OP_W-1:0]   in_opcode;
  logic [ST_W-1:0]   res_status;
  logic [TAG_W-1:0]  res_tag;
  logic [PIDX_W-1:0] res_part;
  pcmd_t             pcmd;
  logic [PW-1:0]     pcmd_idx;
  acmd_t             acmd;
  logic              tag_bump;

  tok_t              p_tok [0:MAX_PARTITIONS];
  logic [PW-1:0]     p_idx [0:MAX_PARTITIONS];
  tok_t              a_tok [0:MAX_ALLOCATIONS];
  logic [AW-1:0]     a_slot [0:MAX_ALLOCATIONS];
  logic [PW-1:0]     a_part [0:MAX_ALLOCATIONS];
  logic [AMT_W-1:0]  a_size [0:MAX_ALLOCATIONS];
  logic [MAX_PARTITIONS-1:0]  p_vld;
  logic [MAX_ALLOCATIONS-1:0] a_vld;

  assign in_opcode = in_tdata[1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign fin_fire  = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_opcode == OP_ALLOC || in_opcode == OP_FREE) ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (p_done_r && a_done_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      p_done_r    <= 1'b0;
      a_done_r    <= 1'b0;
      count_r     <= '0;
      next_tag_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_fire && (in_opcode == OP_ALLOC || in_opcode == OP_FREE);
      if (in_fire) begin
        p_done_r <= 1'b0;
        a_done_r <= 1'b0;
      end else begin
        if (p_tok[MAX_PARTITIONS].vld) begin
          p_done_r <= 1'b1;
        end
        if (a_tok[MAX_ALLOCATIONS].vld) begin
          a_done_r <= 1'b1;
        end
      end
      if (pcmd.code == PCMD_LOAD) begin
        count_r <= count_r + 1'b1;
      end
      if (tag_bump) begin
        next_tag_r <= next_tag_r + 1'b1;
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_opcode;
      amount_r <= in_tdata[17:2];
      rtag_r   <= in_tdata[33:18];
    end
    if (p_tok[MAX_PARTITIONS].vld) begin
      fit_r     <= p_tok[MAX_PARTITIONS].found;
      fit_idx_r <= p_idx[MAX_PARTITIONS];
    end
    if (a_tok[MAX_ALLOCATIONS].vld) begin
      afound_r    <= a_tok[MAX_ALLOCATIONS].found;
      slot_r      <= a_slot[MAX_ALLOCATIONS];
      slot_part_r <= a_part[MAX_ALLOCATIONS];
      slot_size_r <= a_size[MAX_ALLOCATIONS];
    end
    if (fin_fire) begin
      res_status_r <= res_status;
      res_tag_r    <= res_tag;
      res_part_r   <= res_part;
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_tag    = '0;
    res_part   = '0;
    pcmd.code  = PCMD_NONE;
    pcmd.value = amount_r;
    pcmd_idx   = fit_idx_r;
    acmd.set   = 1'b0;
    acmd.clr   = 1'b0;
    acmd.tag   = next_tag_r;
    acmd.size  = amount_r;
    tag_bump   = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        if (count_r == PCOUNT_MAX) begin
          res_status = ST_PART_FULL;
        end else begin
          res_part  = PIDX_W'(count_r[PW-1:0]);
          pcmd.code = PCMD_LOAD;
          pcmd_idx  = count_r[PW-1:0];
        end
      end
      OP_ALLOC: begin
        if (!fit_r) begin
          res_status = ST_NO_FIT;
        end else if (!afound_r) begin
          res_status = ST_ALLOC_FULL;
        end else begin
          res_tag   = next_tag_r;
          res_part  = PIDX_W'(fit_idx_r);
          pcmd.code = PCMD_TAKE;
          acmd.set  = 1'b1;
          tag_bump  = 1'b1;
        end
      end
      OP_FREE: begin
        if (!afound_r) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_part   = PIDX_W'(slot_part_r);
          pcmd.code  = PCMD_GIVE;
          pcmd.value = slot_size_r;
          pcmd_idx   = slot_part_r;
          acmd.clr   = 1'b1;
        end
      end
      default: res_status = ST_OK;
    endcase
    if (!fin_fire) begin
      pcmd.code = PCMD_NONE;
      acmd.set  = 1'b0;
      acmd.clr  = 1'b0;
      tag_bump  = 1'b0;
    end
  end

  assign p_tok[0].vld   = start_r;
  assign p_tok[0].found = 1'b0;
  assign p_idx[0]       = '0;

  for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_pcell
    ffba_pcell #(
      .PW(PW)
    ) u_pcell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (PW'(i)),
      .tok_i     (p_tok[i]),
      .idx_i     (p_idx[i]),
      .amount_i  (amount_r),
      .cmd_i     (pcmd),
      .cmd_idx_i (pcmd_idx),
      .tok_o     (p_tok[i+1]),
      .idx_o     (p_idx[i+1])
    );
    assign p_vld[i] = p_tok[i+1].vld;
  end

  assign a_tok[0].vld   = start_r;
  assign a_tok[0].found = 1'b0;
  assign a_slot[0]      = '0;
  assign a_part[0]      = '0;
  assign a_size[0]      = '0;

  for (genvar j = 0; j < MAX_ALLOCATIONS; j++) begin : g_acell
    ffba_acell #(
      .AW(AW),
      .PW(PW)
    ) u_acell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (AW'(j)),
      .tok_i       (a_tok[j]),
      .slot_i      (a_slot[j]),
      .part_i      (a_part[j]),
      .size_i      (a_size[j]),
      .seek_free_i (op_r == OP_ALLOC),
      .tag_key_i   (rtag_r),
      .cmd_i       (acmd),
      .cmd_slot_i  (slot_r),
      .wr_part_i   (fit_idx_r),
      .tok_o       (a_tok[j+1]),
      .slot_o      (a_slot[j+1]),
      .part_o      (a_part[j+1]),
      .size_o      (a_size[j+1])
    );
    assign a_vld[j] = a_tok[j+1].vld;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_part_r, res_tag_r, res_status_r};

  a_one_ptoken : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(p_vld))
    else $error("More than one search token in the partition chain.");

  a_one_atoken : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(a_vld))
    else $error("More than one search token in the allocation chain.");

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PCOUNT_MAX)
    else $error("Partition count exceeds the table size.");

  a_tag_step : assert property (@(posedge clk) disable iff (!rst_n)
    tag_bump |=> next_tag_r == TAG_W'($past(next_tag_r) + 1'b1))
    else $error("Tag counter did not advance after a successful allocation.");

endmodule : first_fit_block_allocator
`default_nettype wire
